@@ rtl/qrm_pkg.sv @@
`default_nettype none
package qrm_pkg;
    localparam int WordBits = 32;
    localparam int StepBits = WordBits - 1;
    localparam int DivBits  = WordBits + 1;
    localparam int CntBits  = $clog2(DivBits + 1);

    typedef logic signed [WordBits-1:0] t_word;
    typedef logic [StepBits-1:0] t_step;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_FIT_LO,
        ST_FIT_HI,
        ST_GCD,
        ST_LCM_DIV,
        ST_LCM_MUL,
        ST_START_DIV,
        ST_START_MUL,
        ST_END_DIV,
        ST_END_MUL,
        ST_DONE
    } t_state;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLASSIFY,
        OP_FIT_LO_DIV,
        OP_FIT_HI_DIV,
        OP_GCD_DIV,
        OP_LCM_DIV,
        OP_LCM_MUL,
        OP_START_DIV,
        OP_START_MUL,
        OP_END_DIV,
        OP_END_MUL,
        OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        CLS_COPY,
        CLS_FAIL,
        CLS_EQUAL,
        CLS_FIT,
        CLS_LCM
    } t_class;

    typedef struct packed {
        t_op  op;
        logic div_start;
    } t_cmd;

    typedef struct packed {
        t_class cls;
        logic   div_done;
        logic   gcd_zero;
        logic   lcm_wide;
        logic   start_out;
    } t_status;
endpackage
`default_nettype wire

@@ rtl/qrm_divider.sv @@
`default_nettype none
module qrm_divider (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [qrm_pkg::DivBits-1:0] i_num,
    input  wire logic [qrm_pkg::DivBits-1:0] i_den,
    output logic                             o_done,
    output logic [qrm_pkg::DivBits-1:0]      o_quo,
    output logic [qrm_pkg::DivBits-1:0]      o_rem
);
    import qrm_pkg::*;

    // Restoring divider, one quotient bit per cycle, unsigned operands.
    logic [DivBits-1:0] r_den, r_quo, r_rem;
    logic [DivBits-1:0] n_quo, n_rem;
    logic [CntBits-1:0] r_cnt;
    logic               r_busy, r_done;
    logic [DivBits:0]   w_trial;

    always_comb begin
        w_trial = {r_rem, r_quo[DivBits-1]};
        n_quo   = {r_quo[DivBits-2:0], 1'b0};
        n_rem   = w_trial[DivBits-1:0];
        if (w_trial >= {1'b0, r_den}) begin
            n_rem    = DivBits'(w_trial - {1'b0, r_den});
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntBits'(DivBits);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntBits'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_quo <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

    property p_done_single;
        @(posedge i_clk) disable iff (!i_rst_n) o_done |=> !o_done;
    endproperty
    a_done_single: assert property (p_done_single) else $error("done held");

    property p_done_from_busy;
        @(posedge i_clk) disable iff (!i_rst_n) $rose(r_done) |-> $past(r_busy);
    endproperty
    a_done_from_busy: assert property (p_done_from_busy) else $error("stray done");

    property p_cnt_idle;
        @(posedge i_clk) disable iff (!i_rst_n) !r_busy |-> r_cnt == '0 || $past(!i_rst_n);
    endproperty
    a_cnt_idle: assert property (p_cnt_idle) else $error("counter left");
endmodule
`default_nettype wire

@@ rtl/qrm_datapath.sv @@
`default_nettype none
module qrm_datapath (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire qrm_pkg::t_cmd   i_cmd,
    input  wire qrm_pkg::t_word  i_first_low,
    input  wire qrm_pkg::t_word  i_first_high,
    input  wire qrm_pkg::t_step  i_first_step,
    input  wire qrm_pkg::t_word  i_second_low,
    input  wire qrm_pkg::t_word  i_second_high,
    input  wire qrm_pkg::t_step  i_second_step,
    output qrm_pkg::t_status     o_status,
    output logic                 o_ok,
    output qrm_pkg::t_word       o_low,
    output qrm_pkg::t_word       o_high,
    output qrm_pkg::t_step       o_step
);
    import qrm_pkg::*;

    t_word  r_l1, r_h1, r_l2, r_h2;
    t_step  r_s1, r_s2;
    t_class r_cls;
    // Grid and fit operands.
    t_word  r_gl, r_gh;
    t_step  r_gs;
    // Gcd pair, lcm and result registers.
    logic [DivBits-1:0] r_ga, r_gb;
    logic [DivBits-1:0] r_q;
    logic [63:0]        r_prod;
    t_word  r_base, r_bmin, r_bmax;
    t_word  r_rl, r_rh;
    t_step  r_rs;
    logic   r_ok, r_start_out;

    logic               w_div_done;
    logic [DivBits-1:0] w_quo, w_rem, w_num, w_den;

    logic signed [WordBits+1:0] w_sum;
    logic signed [WordBits:0] w_bmax_ext, w_start;

    qrm_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // Fit dividend: (v - lo) + step/2, with v unclamped (clamp handled in fit_val).
    function automatic logic [DivBits-1:0] fit_num(t_word v, t_word lo, t_step s);
        logic signed [WordBits+1:0] d;
        d = {{2{v[WordBits-1]}}, v} - {{2{lo[WordBits-1]}}, lo}
            + (WordBits+2)'({1'b0, s[StepBits-1:1]});
        return DivBits'(d);
    endfunction

    function automatic t_word fit_val(t_word v, t_word lo, t_word hi, t_step s,
                                      logic [DivBits-1:0] quo);
        logic [63:0] p;
        logic signed [WordBits+1:0] r;
        p = 64'(quo) * 64'(s);
        r = (WordBits+2)'(p) + {{2{lo[WordBits-1]}}, lo};
        if ($signed(v) < $signed(lo)) return lo;
        if ($signed(v) > $signed(hi)) return hi;
        if (r > $signed({{2{hi[WordBits-1]}}, hi})) return hi;
        return t_word'(r);
    endfunction

    always_comb begin
        w_num = '0;
        w_den = {2'b0, r_gs};
        case (i_cmd.op)
            OP_FIT_LO_DIV: w_num = fit_num(r_l1, r_gl, r_gs);
            OP_FIT_HI_DIV: w_num = fit_num(r_h1, r_gl, r_gs);
            OP_GCD_DIV: begin
                w_num = r_ga;
                w_den = r_gb;
            end
            OP_LCM_DIV: begin
                w_num = {2'b0, r_s1};
                w_den = r_ga;
            end
            OP_START_DIV: begin
                w_num = DivBits'({{2{r_bmin[WordBits-1]}}, r_bmin}
                        - {{2{r_base[WordBits-1]}}, r_base}
                        + (WordBits+2)'(r_prod[DivBits-1:0]) - (WordBits+2)'(1));
                w_den = r_prod[DivBits-1:0];
            end
            OP_END_DIV: begin
                w_num = DivBits'({r_bmax[WordBits-1], r_bmax} - {r_rl[WordBits-1], r_rl});
                w_den = r_q;
            end
            default: ;
        endcase
    end

    assign w_sum      = (WordBits+2)'(r_prod) + {{2{r_base[WordBits-1]}}, r_base};
    assign w_bmax_ext = {r_bmax[WordBits-1], r_bmax};
    assign w_start    = w_sum[WordBits:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok <= 1'b0;
            r_cls <= CLS_FAIL;
            r_start_out <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_l1 <= i_first_low;
                    r_h1 <= i_first_high;
                    r_s1 <= i_first_step;
                    r_l2 <= i_second_low;
                    r_h2 <= i_second_high;
                    r_s2 <= i_second_step;
                    r_ok <= 1'b0;
                    r_start_out <= 1'b0;
                end
                OP_CLASSIFY: begin
                    r_base <= (r_l1 < r_l2) ? r_l1 : r_l2;
                    r_bmin <= (r_l1 > r_l2) ? r_l1 : r_l2;
                    r_bmax <= (r_h1 < r_h2) ? r_h1 : r_h2;
                    r_ga   <= {2'b0, r_s1};
                    r_gb   <= {2'b0, r_s2};
                    if (r_l1 == r_l2 && r_h1 == r_h2 && r_s1 == r_s2) begin
                        r_cls <= CLS_COPY;
                        r_rl <= r_l1; r_rh <= r_h1; r_rs <= r_s1; r_ok <= 1'b1;
                    end else if (!(r_h1 >= r_l2 && r_h2 >= r_l1)) begin
                        r_cls <= CLS_FAIL;
                    end else if (r_s1 == r_s2) begin
                        r_cls <= CLS_EQUAL;
                        r_rl <= (r_l1 > r_l2) ? r_l1 : r_l2;
                        r_rh <= (r_h1 < r_h2) ? r_h1 : r_h2;
                        r_rs <= r_s1; r_ok <= 1'b1;
                    end else if (r_s1 == '0 || r_s2 == '0) begin
                        r_cls <= CLS_FIT;
                        r_ok  <= 1'b1;
                        // Grid into r_g*, unstepped range into r_l1/r_h1.
                        if (r_s1 == '0) begin
                            r_gl <= r_l2; r_gh <= r_h2; r_gs <= r_s2;
                        end else begin
                            r_gl <= r_l1; r_gh <= r_h1; r_gs <= r_s1;
                            r_l1 <= r_l2; r_h1 <= r_h2;
                        end
                    end else begin
                        r_cls <= CLS_LCM;
                    end
                end
                OP_FIT_LO_DIV: if (w_div_done) r_rl <= fit_val(r_l1, r_gl, r_gh, r_gs, w_quo);
                OP_FIT_HI_DIV: begin
                    if (w_div_done) begin
                        r_rh <= fit_val(r_h1, r_gl, r_gh, r_gs, w_quo);
                        r_rs <= r_gs;
                    end
                end
                OP_GCD_DIV: begin
                    if (w_div_done) begin
                        r_ga <= r_gb;
                        r_gb <= w_rem;
                    end
                end
                OP_LCM_DIV: if (w_div_done) r_q <= w_quo;
                OP_LCM_MUL: r_prod <= 64'(r_q) * 64'(r_s2);
                OP_START_DIV: begin
                    if (w_div_done) r_q <= r_prod[DivBits-1:0];
                end
                OP_END_DIV: if (w_div_done) r_prod <= 64'(w_quo) * 64'(r_q);
                OP_END_MUL: begin
                    r_rh <= t_word'(r_prod[WordBits-1:0] + r_rl);
                    r_rs <= r_q[StepBits-1:0];
                    r_ok <= 1'b1;
                end
                OP_FINISH: begin
                    if (!r_ok) begin
                        r_rl <= '0; r_rh <= '0; r_rs <= '0;
                    end
                end
                default: ;
            endcase
            // Start point multiply runs off the start quotient.
            if (i_cmd.op == OP_START_DIV && w_div_done) begin
                r_prod <= 64'(w_quo) * 64'(r_prod[DivBits-1:0]);
            end
            if (i_cmd.op == OP_START_MUL) begin
                r_rl <= t_word'(w_start);
                r_start_out <= (w_start > w_bmax_ext);
            end
        end
    end

    // The lcm product sits in r_prod after OP_LCM_MUL; START_DIV keeps it as q.
    assign o_status.cls       = r_cls;
    assign o_status.div_done  = w_div_done;
    assign o_status.gcd_zero  = (r_gb == '0);
    assign o_status.lcm_wide  = (r_prod > 64'((64'd1 << StepBits) - 64'd1));
    assign o_status.start_out = r_start_out;
    assign o_ok   = r_ok;
    assign o_low  = r_rl;
    assign o_high = r_rh;
    assign o_step = r_rs;

    property p_fail_zero;
        @(posedge i_clk) disable iff (!i_rst_n)
            $past(i_cmd.op == OP_FINISH) && !o_ok |-> o_low == '0 && o_high == '0 && o_step == '0;
    endproperty
    a_fail_zero: assert property (p_fail_zero) else $error("failure not cleared");

    property p_ok_order;
        @(posedge i_clk) disable iff (!i_rst_n)
            $past(i_cmd.op == OP_FINISH) && o_ok |-> $signed(o_low) <= $signed(o_high)
            || r_cls == CLS_COPY || r_cls == CLS_EQUAL || r_cls == CLS_FIT;
    endproperty
    a_ok_order: assert property (p_ok_order) else $error("lcm range inverted");

    property p_load_clears;
        @(posedge i_clk) disable iff (!i_rst_n) $past(i_cmd.op == OP_LOAD) |-> !o_ok;
    endproperty
    a_load_clears: assert property (p_load_clears) else $error("stale ok");
endmodule
`default_nettype wire

@@ rtl/qrm_control.sv @@
`default_nettype none
module qrm_control (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire qrm_pkg::t_status  i_status,
    output qrm_pkg::t_cmd          o_cmd,
    output logic                   o_busy,
    output logic                   o_valid
);
    import qrm_pkg::*;

    t_state r_state, n_state;
    logic   r_issued, n_issued;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
        end
    end

    // Each dividing state issues one divider start, then waits for done; ST_GCD issues one per Euclid step.
    always_comb begin
        n_state       = r_state;
        n_issued      = r_issued;
        o_cmd.op      = OP_NONE;
        o_cmd.div_start = 1'b0;
        o_busy        = (r_state != ST_IDLE);
        o_valid       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                o_cmd.op = OP_CLASSIFY;
                n_state  = ST_DONE;
                n_issued = 1'b0;
            end
            default: ;
        endcase
        // Classification is registered, so the branch decision is made one
        // state later for the fit and lcm paths.
        case (r_state)
            ST_DONE: begin
                if (r_issued == 1'b0 && i_status.cls == CLS_FIT) begin
                    n_state = ST_FIT_LO;
                end else if (r_issued == 1'b0 && i_status.cls == CLS_LCM) begin
                    n_state = ST_GCD;
                end else begin
                    o_cmd.op = OP_FINISH;
                    o_valid  = 1'b0;
                    n_state  = ST_IDLE;
                    o_valid  = 1'b1;
                end
                if (r_issued == 1'b0 && (i_status.cls == CLS_FIT || i_status.cls == CLS_LCM))
                    o_valid = 1'b0;
                if (r_issued == 1'b0 && (i_status.cls == CLS_FIT || i_status.cls == CLS_LCM))
                    o_cmd.op = OP_NONE;
            end
            ST_FIT_LO: begin
                o_cmd.op = OP_FIT_LO_DIV;
                o_cmd.div_start = !r_issued;
                n_issued = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_FIT_HI; n_issued = 1'b0;
                end
            end
            ST_FIT_HI: begin
                o_cmd.op = OP_FIT_HI_DIV;
                o_cmd.div_start = !r_issued;
                n_issued = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_GCD: begin
                if (!r_issued && i_status.gcd_zero) begin
                    n_state = ST_LCM_DIV;
                end else begin
                    o_cmd.op = OP_GCD_DIV;
                    o_cmd.div_start = !r_issued;
                    n_issued = 1'b1;
                    if (i_status.div_done) n_issued = 1'b0;
                end
            end
            ST_LCM_DIV: begin
                o_cmd.op = OP_LCM_DIV;
                o_cmd.div_start = !r_issued;
                n_issued = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_LCM_MUL; n_issued = 1'b0;
                end
            end
            ST_LCM_MUL: begin
                o_cmd.op = OP_LCM_MUL;
                n_state  = ST_START_DIV;
            end
            ST_START_DIV: begin
                if (!r_issued && i_status.lcm_wide) begin
                    n_state  = ST_DONE;
                    n_issued = 1'b1;
                end else begin
                    o_cmd.op = OP_START_DIV;
                    o_cmd.div_start = !r_issued;
                    n_issued = 1'b1;
                    if (i_status.div_done) begin
                        n_state = ST_START_MUL; n_issued = 1'b0;
                    end
                end
            end
            ST_START_MUL: begin
                o_cmd.op = OP_START_MUL;
                n_state  = ST_END_DIV;
            end
            ST_END_DIV: begin
                if (!r_issued && i_status.start_out) begin
                    n_state  = ST_DONE;
                    n_issued = 1'b1;
                end else begin
                    o_cmd.op = OP_END_DIV;
                    o_cmd.div_start = !r_issued;
                    n_issued = 1'b1;
                    if (i_status.div_done) n_state = ST_END_MUL;
                end
            end
            ST_END_MUL: begin
                o_cmd.op = OP_END_MUL;
                n_state  = ST_DONE;
                n_issued = 1'b1;
            end
            default: ;
        endcase
    end

    property p_valid_in_done;
        @(posedge i_clk) disable iff (!i_rst_n) o_valid |-> r_state == ST_DONE;
    endproperty
    a_valid_in_done: assert property (p_valid_in_done) else $error("valid outside done");

    property p_valid_then_idle;
        @(posedge i_clk) disable iff (!i_rst_n) o_valid |=> r_state == ST_IDLE;
    endproperty
    a_valid_then_idle: assert property (p_valid_then_idle) else $error("no return to idle");

    property p_start_loads;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_start && r_state == ST_IDLE |=> r_state == ST_CLASSIFY;
    endproperty
    a_start_loads: assert property (p_start_loads) else $error("start missed");
endmodule
`default_nettype wire

@@ rtl/quantized_range_merge.sv @@
`default_nettype none
// Quantized range merge. Raise start while busy is low to hand in two
// ranges; the merged range appears on the o_merged_* ports for exactly one
// cycle, marked by o_valid, and the receiver cannot hold it off, so it must
// capture it in that cycle. One item is worked on at a time. The identical,
// disjoint and equal-step cases need no divider pass. The shared radix-2
// divider works a pass as a start, 33 quotient bits and a done, and the fit
// case needs two passes. The lcm case runs one divider pass per Euclid step
// of the gcd (at most about 45 steps), then up to three more.
module quantized_range_merge (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire qrm_pkg::t_word  i_first_low,
    input  wire qrm_pkg::t_word  i_first_high,
    input  wire qrm_pkg::t_step  i_first_step,
    input  wire qrm_pkg::t_word  i_second_low,
    input  wire qrm_pkg::t_word  i_second_high,
    input  wire qrm_pkg::t_step  i_second_step,
    output logic                 o_valid,
    output logic                 o_merged_ok,
    output qrm_pkg::t_word       o_merged_low,
    output qrm_pkg::t_word       o_merged_high,
    output qrm_pkg::t_step       o_merged_step
);
    import qrm_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_valid;

    // Control sequences the cases; the datapath holds operands and the divider.
    qrm_control u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_valid  (w_valid)
    );

    qrm_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_first_low   (i_first_low),
        .i_first_high  (i_first_high),
        .i_first_step  (i_first_step),
        .i_second_low  (i_second_low),
        .i_second_high (i_second_high),
        .i_second_step (i_second_step),
        .o_status      (w_status),
        .o_ok          (o_merged_ok),
        .o_low         (o_merged_low),
        .o_high        (o_merged_high),
        .o_step        (o_merged_step)
    );

    // The finish command clears failed results at this edge, so the strobe is
    // registered and follows in the cycle after the controller issues it.
    logic r_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_valid;
        end
    end
    assign o_valid = r_valid;

    property p_valid_pulse;
        @(posedge i_clk) disable iff (!i_rst_n) o_valid |=> !o_valid;
    endproperty
    a_valid_pulse: assert property (p_valid_pulse) else $error("beat repeated");

    property p_valid_idle;
        @(posedge i_clk) disable iff (!i_rst_n) o_valid |-> !busy;
    endproperty
    a_valid_idle: assert property (p_valid_idle) else $error("beat while busy");

    property p_fail_clean;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_valid && !o_merged_ok |-> o_merged_low == '0 && o_merged_step == '0;
    endproperty
    a_fail_clean: assert property (p_fail_clean) else $error("dirty failure beat");
endmodule
`default_nettype wire

@@ tb/sv/quantized_range_merge_test.sv @@
`timescale 1ns / 1ps

// A range as the block sees it: minimum, maximum and quantization step.
typedef struct {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [30:0]        step;
} range_t;

// The merged range that the block should deliver for one beat.
typedef struct {
    logic               ok;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [30:0]        step;
} merged_t;

// Tracks merged ranges still owed by the block and checks each one delivered.
class merge_scoreboard;
    merged_t pending[$];
    int      errors;

    function new();
        errors = 0;
    endfunction

    // Snap v onto the stepped grid: clamp, round half up from the grid
    // minimum, then cap at the grid maximum.
    static function longint snap_to_grid(longint lo, longint hi, longint step, longint v);
        longint d;
        if (v < lo) return lo;
        if (v > hi) return hi;
        d = v - lo;
        d = ((d + step / 2) / step) * step;
        return (d + lo < hi) ? d + lo : hi;
    endfunction

    static function merged_t merge_ranges(range_t a, range_t b);
        merged_t r;
        longint  l1, h1, s1, l2, h2, s2, x, y, t, q, base, bmin, bmax, k, first_pt;
        l1 = a.lo; h1 = a.hi; s1 = a.step;
        l2 = b.lo; h2 = b.hi; s2 = b.step;
        r.ok = 1'b0; r.lo = '0; r.hi = '0; r.step = '0;
        if (l1 == l2 && h1 == h2 && s1 == s2) begin
            r.ok = 1'b1; r.lo = 32'(l1); r.hi = 32'(h1); r.step = 31'(s1);
        end else if (!(h1 >= l2 && h2 >= l1)) begin
            r.ok = 1'b0;
        end else if (s1 == s2) begin
            r.ok = 1'b1;
            r.lo = 32'((l1 > l2) ? l1 : l2);
            r.hi = 32'((h1 < h2) ? h1 : h2);
            r.step = 31'(s1);
        end else if (s1 == 0) begin
            r.ok = 1'b1;
            r.lo = 32'(snap_to_grid(l2, h2, s2, l1));
            r.hi = 32'(snap_to_grid(l2, h2, s2, h1));
            r.step = 31'(s2);
        end else if (s2 == 0) begin
            r.ok = 1'b1;
            r.lo = 32'(snap_to_grid(l1, h1, s1, l2));
            r.hi = 32'(snap_to_grid(l1, h1, s1, h2));
            r.step = 31'(s1);
        end else begin
            x = s1; y = s2;
            while (y != 0) begin
                t = x % y; x = y; y = t;
            end
            q = (s1 / x) * s2;
            if (q <= 64'sh7FFF_FFFF) begin
                base = (l1 < l2) ? l1 : l2;
                bmin = (l1 > l2) ? l1 : l2;
                bmax = (h1 < h2) ? h1 : h2;
                k = (bmin - base + q - 1) / q;
                first_pt = base + k * q;
                if (first_pt <= bmax) begin
                    r.ok = 1'b1;
                    r.lo = 32'(first_pt);
                    r.hi = 32'(first_pt + ((bmax - first_pt) / q) * q);
                    r.step = 31'(q);
                end
            end
        end
        if (!r.ok) begin
            r.lo = '0; r.hi = '0; r.step = '0;
        end
        return r;
    endfunction

    function void note_input(range_t a, range_t b);
        pending.push_back(merge_ranges(a, b));
    endfunction

    function void check_result(merged_t got);
        merged_t want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result ok=%0b lo=%0d hi=%0d step=%0d",
                     $time, got.ok, got.lo, got.hi, got.step);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.ok !== want.ok) begin
            $display("%0t: ok expected %0b actual %0b", $time, want.ok, got.ok);
            errors++;
        end
        if (got.lo !== want.lo) begin
            $display("%0t: low expected %0d actual %0d", $time, want.lo, got.lo);
            errors++;
        end
        if (got.hi !== want.hi) begin
            $display("%0t: high expected %0d actual %0d", $time, want.hi, got.hi);
            errors++;
        end
        if (got.step !== want.step) begin
            $display("%0t: step expected %0d actual %0d", $time, want.step, got.step);
            errors++;
        end
    endfunction
endclass

module quantized_range_merge_test;
    import qrm_pkg::*;

    // The lcm case is the slowest beat, so the
    // cycle limit is sized from that worst case plus sender gaps, many times over.
    localparam int CycleLimit = 20_000_000;
    localparam int NumRandom  = 1130;

    logic  i_clk = 0;
    logic  i_rst_n = 0;
    logic  start = 0;
    logic  busy;
    t_word i_first_low = 0, i_first_high = 0, i_second_low = 0, i_second_high = 0;
    t_step i_first_step = 0, i_second_step = 0;
    logic  o_valid, o_merged_ok;
    t_word o_merged_low, o_merged_high;
    t_step o_merged_step;

    merge_scoreboard board = new();
    int    idle_pct = 0;
    int    cycles = 0;

    quantized_range_merge uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_first_low(i_first_low), .i_first_high(i_first_high),
        .i_first_step(i_first_step), .i_second_low(i_second_low),
        .i_second_high(i_second_high), .i_second_step(i_second_step),
        .o_valid(o_valid), .o_merged_ok(o_merged_ok), .o_merged_low(o_merged_low),
        .o_merged_high(o_merged_high), .o_merged_step(o_merged_step)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Results are sampled at the edge that ends their cycle; the receiver never stalls.
    always @(posedge i_clk) begin
        merged_t got;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            got.ok = o_merged_ok; got.lo = o_merged_low;
            got.hi = o_merged_high; got.step = o_merged_step;
            board.check_result(got);
        end
        if (cycles > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Hand one beat to the block: optional idle cycles, then hold start until
    // an edge sees start high with busy low. start drops only for idle cycles
    // and after the last beat.
    task automatic send_ranges(range_t a, range_t b);
        if ($urandom_range(99) < idle_pct) begin
            start <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start         <= 1;
        i_first_low   <= a.lo;   i_first_high  <= a.hi;   i_first_step  <= a.step;
        i_second_low  <= b.lo;   i_second_high <= b.hi;   i_second_step <= b.step;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_input(a, b);
    endtask

    function automatic range_t make_range(longint lo, longint hi, longint step);
        range_t r;
        r.lo = 32'(lo); r.hi = 32'(hi); r.step = 31'(step);
        return r;
    endfunction

    // Random value, mostly small so that ranges overlap, sometimes the full word.
    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(2000)) - 1000;
            default: return $signed($urandom_range(200000)) - 100000;
        endcase
    endfunction

    function automatic logic [30:0] rand_step();
        case ($urandom_range(5))
            0: return '0;
            1: return 31'($urandom);
            2: return 31'($urandom_range(60000, 1));
            default: return 31'($urandom_range(40, 1));
        endcase
    endfunction

    function automatic range_t rand_range();
        range_t r;
        r.lo = rand_value();
        r.hi = ($urandom_range(9) == 0) ? rand_value()
             : r.lo + $signed({1'b0, 31'($urandom_range(200000))});
        if (r.hi < r.lo && $urandom_range(3) != 0) r.hi = r.lo;
        r.step = rand_step();
        return r;
    endfunction

    initial begin
        range_t a, b;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed beats: each merge case, word extremes and the failure paths.
        send_ranges(make_range(-10, 10, 2), make_range(-10, 10, 2));          // copy
        send_ranges(make_range(0, 5, 1), make_range(6, 9, 1));                 // disjoint
        send_ranges(make_range(0, 100, 5), make_range(20, 200, 5));            // equal steps
        send_ranges(make_range(0, 100, 10), make_range(14, 96, 0));            // fit, round
        send_ranges(make_range(3, 40, 0), make_range(0, 100, 10));             // fit, grid in second
        send_ranges(make_range(-50, 500, 0), make_range(0, 95, 10));           // fit, clamp
        send_ranges(make_range(0, 97, 10), make_range(1, 97, 0));              // fit, cap at max
        send_ranges(make_range(0, 100, 4), make_range(3, 90, 6));              // lcm
        send_ranges(make_range(0, 10, 4), make_range(1, 11, 6));               // empty grid
        send_ranges(make_range(0, 1000, 65537), make_range(0, 1000, 65539));   // wide lcm
        send_ranges(make_range(-32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF),
                    make_range(-32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF));
        send_ranges(make_range(-32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF),
                    make_range(-32'sh8000_0000, 32'sh7FFF_FFFF, 0));
        send_ranges(make_range(-32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF),
                    make_range(-32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFE));
        send_ranges(make_range(-32'sh8000_0000, 32'sh7FFF_FFFF, 1),
                    make_range(-32'sh8000_0000, 32'sh7FFF_FFFF, 2));
        send_ranges(make_range(-32'sh8000_0000, -32'sh8000_0000, 0),
                    make_range(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0));
        send_ranges(make_range(10, 0, 3), make_range(5, 5, 0));                // inverted
        send_ranges(make_range(10, 0, 0), make_range(-5, 20, 7));
        send_ranges(make_range(0, 1000000, 832040), make_range(0, 1000000, 514229));
        send_ranges(make_range(-1, -1, 31'h5555_5555), make_range(-1, -1, 31'h2AAA_AAAA));

        // Random beats in three idling phases: 25 %, 45 %, then none.
        for (int n = 0; n < NumRandom; n++) begin
            idle_pct = (n < NumRandom / 3) ? 25 : (n < 2 * NumRandom / 3) ? 45 : 0;
            a = rand_range();
            case ($urandom_range(9))
                0: b = a;
                1: begin b = rand_range(); b.step = a.step; end
                default: b = rand_range();
            endcase
            if ($urandom_range(3) == 0) b.lo = a.lo + $signed($urandom_range(100)) - 50;
            send_ranges(a, b);
        end
        start <= 0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/qrm_pkg.sv
rtl/qrm_divider.sv
rtl/qrm_datapath.sv
rtl/qrm_control.sv
rtl/quantized_range_merge.sv
tb/sv/quantized_range_merge_test.sv
